[sv/dvbtm_pkg.sv]
package dvbtm_pkg;

	// Field widths of the request and response items
	localparam int CMD_W   = 3;
	localparam int TX_ID_W = 4;
	localparam int ADDR_W  = 12;
	localparam int DATA_W  = 8;
	localparam int COUNT_W = 5;
	localparam int EPOCH_W = 16;

	// Command codes
	localparam logic [CMD_W-1:0] CMD_BEGIN = 3'd0;
	localparam logic [CMD_W-1:0] CMD_READ  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_WRITE = 3'd2;
	localparam logic [CMD_W-1:0] CMD_END   = 3'd3;
	localparam logic [CMD_W-1:0] CMD_ABORT = 3'd4;

	// Saturation point of the waiting counter
	localparam logic [COUNT_W-1:0] COUNT_MAX = 5'd31;

	typedef struct packed {
		logic [CMD_W-1:0]   command;
		logic [TX_ID_W-1:0] tx_id;
		logic               ro_mode;
		logic [ADDR_W-1:0]  address;
		logic [DATA_W-1:0]  write_data;
	} req_t;

	typedef struct packed {
		logic               success;
		logic [DATA_W-1:0]  read_data;
		logic               admitted;
		logic               epoch_advanced;
		logic [COUNT_W-1:0] released_count;
		logic [EPOCH_W-1:0] epoch_number;
	} rsp_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_EXEC,
		ST_SWEEP,
		ST_FLUSH
	} state_t;

endpackage

[sv/dual_version_batched_tx_memory.sv]
// Byte-granular transactional memory with a committed and a pending copy
// of every byte, run in epochs.
// Request channel (req_valid/req_stall/req) carries begin, read, write,
// end and abort commands; the response channel (rsp_valid/rsp_stall/rsp)
// returns exactly one response per request, in order.
// An accepted request reads its store entry in the accept cycle and
// does its read-modify-write in ST_EXEC once the response register is
// free; no new request is taken before then, as there is a single store
// read port. The response is registered when the read-modify-write fires.
// When the last active transaction leaves, the store is swept one entry
// per cycle, with req_stall high through the sweep and the flush. The
// response of the closing request is shown at the start of the sweep.
// After reset the store is cleared entry by entry with req_stall high.
// A stalled response holds in its register; a new request is still taken,
// and its read-modify-write waits until the response register frees up.
module dual_version_batched_tx_memory #(
	parameter int MEM_BYTES = 4096,
	parameter int MAX_TX    = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_stall,
	input  dvbtm_pkg::req_t   req,
	output logic              rsp_valid,
	input  logic              rsp_stall,
	output dvbtm_pkg::rsp_t   rsp
);

	localparam int AW      = $clog2(MEM_BYTES);
	localparam int TX_W    = $clog2(MAX_TX);
	localparam int TX_SPAN = 1 << dvbtm_pkg::TX_ID_W;
	localparam int CW      = dvbtm_pkg::COUNT_W;
	localparam int EW      = dvbtm_pkg::EPOCH_W;
	localparam int DW      = dvbtm_pkg::DATA_W;
	localparam logic [AW-1:0] CNT_LAST = AW'(MEM_BYTES - 1);

	typedef logic [TX_SPAN-1:0][TX_W-1:0] tx_lut_t;

	typedef struct packed {
		logic [DW-1:0]   committed;
		logic [DW-1:0]   pending;
		logic            written;
		logic            foreign;
		logic            owned;
		logic [TX_W-1:0] owner;
	} word_t;

	// Transaction id folded into the supported range
	function automatic tx_lut_t make_tx_lut();
		tx_lut_t lut;
		for (int i = 0; i < TX_SPAN; i++) begin
			lut[i] = TX_W'(i % MAX_TX);
		end
		return lut;
	endfunction

	localparam tx_lut_t TX_LUT = make_tx_lut();

	dvbtm_pkg::state_t state_q, state_nx;

	word_t             mem [MEM_BYTES];
	word_t             rd_q;
	logic [AW-1:0]     rd_addr;
	logic              wr_en;
	logic [AW-1:0]     wr_addr;
	word_t             wr_word;

	logic [AW-1:0]     fold_index;
	logic [AW-1:0]     cnt_q;
	logic              sweep_wb_s1;
	logic [AW-1:0]     sweep_addr_s1;
	word_t             swept;

	dvbtm_pkg::req_t   req_s1;
	logic [AW-1:0]     addr_s1;
	logic [TX_W-1:0]   txi_s1;

	logic [MAX_TX-1:0] tx_ro_q;
	logic [MAX_TX-1:0] tx_done_q;
	logic [CW-1:0]     active_q, waiting_q;
	logic [EW-1:0]     epoch_q;

	logic              accept;
	logic              exec_fire;
	word_t             word_nx;
	logic              ex_success, ex_admitted, ex_leave, ex_close, ex_access;
	logic [DW-1:0]     ex_rdata;
	logic              ro_flag, mine;
	logic [CW-1:0]     active_nx, waiting_nx;
	logic [EW-1:0]     epoch_nx;

	logic              rsp_valid_q;
	dvbtm_pkg::rsp_t   rsp_q;

	dvbtm_addr_fold #(
		.MEM_BYTES(MEM_BYTES)
	) u_fold (
		.address(req.address),
		.index  (fold_index)
	);

	assign accept = req_valid && !req_stall;

	// Hold the state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dvbtm_pkg::ST_CLEAR;
		end else begin
			state_q <= state_nx;
		end
	end

	// Sequence clearing, execution and the epoch sweep; steer the store ports
	always_comb begin
		state_nx  = state_q;
		req_stall = 1'b1;
		exec_fire = 1'b0;
		rd_addr   = addr_s1;
		wr_en     = 1'b0;
		wr_addr   = addr_s1;
		wr_word   = word_nx;
		case (state_q)
			dvbtm_pkg::ST_CLEAR: begin
				wr_en   = 1'b1;
				wr_addr = cnt_q;
				wr_word = '0;
				if (cnt_q == CNT_LAST) begin
					state_nx = dvbtm_pkg::ST_IDLE;
				end
			end
			dvbtm_pkg::ST_IDLE: begin
				req_stall = 1'b0;
				rd_addr   = fold_index;
				if (req_valid) begin
					state_nx = dvbtm_pkg::ST_EXEC;
				end
			end
			dvbtm_pkg::ST_EXEC: begin
				exec_fire = !rsp_valid_q || !rsp_stall;
				wr_en     = exec_fire && ex_access;
				if (exec_fire) begin
					state_nx = ex_close ? dvbtm_pkg::ST_SWEEP : dvbtm_pkg::ST_IDLE;
				end
			end
			dvbtm_pkg::ST_SWEEP: begin
				rd_addr = cnt_q;
				wr_en   = sweep_wb_s1;
				wr_addr = sweep_addr_s1;
				wr_word = swept;
				if (cnt_q == CNT_LAST) begin
					state_nx = dvbtm_pkg::ST_FLUSH;
				end
			end
			dvbtm_pkg::ST_FLUSH: begin
				wr_en    = sweep_wb_s1;
				wr_addr  = sweep_addr_s1;
				wr_word  = swept;
				state_nx = dvbtm_pkg::ST_IDLE;
			end
			default: begin
				state_nx = dvbtm_pkg::ST_CLEAR;
			end
		endcase
	end

	// Store: one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_word;
		end
		rd_q <= mem[rd_addr];
	end

	// Advance the sweep counter while clearing or sweeping
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			sweep_wb_s1 <= 1'b0;
		end else begin
			if (state_q == dvbtm_pkg::ST_CLEAR || state_q == dvbtm_pkg::ST_SWEEP) begin
				cnt_q <= cnt_q + AW'(1);
			end else begin
				cnt_q <= '0;
			end
			sweep_wb_s1 <= (state_q == dvbtm_pkg::ST_SWEEP);
		end
	end

	always_ff @(posedge clk) begin
		sweep_addr_s1 <= cnt_q;
	end

	// Commit a written byte of a committed owner and drop all marks
	always_comb begin
		swept = rd_q;
		if (rd_q.written && rd_q.owned && tx_done_q[rd_q.owner]) begin
			swept.committed = rd_q.pending;
		end
		swept.written = 1'b0;
		swept.foreign = 1'b0;
		swept.owned   = 1'b0;
		swept.owner   = '0;
	end

	// Capture the accepted transaction
	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1  <= req;
			addr_s1 <= fold_index;
			txi_s1  <= TX_LUT[req.tx_id];
		end
	end

	// Apply the command to the entry and the epoch counters
	always_comb begin
		word_nx     = rd_q;
		ex_success  = 1'b0;
		ex_rdata    = '0;
		ex_admitted = 1'b0;
		ex_leave    = 1'b0;
		ex_close    = 1'b0;
		ex_access   = 1'b0;
		active_nx   = active_q;
		waiting_nx  = waiting_q;
		epoch_nx    = epoch_q;
		ro_flag     = tx_ro_q[txi_s1];
		mine        = rd_q.owned && (rd_q.owner == txi_s1);
		case (req_s1.command)
			dvbtm_pkg::CMD_BEGIN: begin
				ex_success = 1'b1;
				if (active_q == '0) begin
					active_nx   = CW'(1);
					ex_admitted = 1'b1;
				end else if (waiting_q < dvbtm_pkg::COUNT_MAX) begin
					waiting_nx = waiting_q + CW'(1);
				end
			end
			dvbtm_pkg::CMD_READ: begin
				ex_access = 1'b1;
				if (ro_flag) begin
					ex_rdata   = rd_q.committed;
					ex_success = 1'b1;
				end else if (rd_q.written) begin
					if (mine) begin
						ex_rdata   = rd_q.pending;
						ex_success = 1'b1;
					end
				end else begin
					ex_rdata = rd_q.committed;
					if (rd_q.owned && !mine) begin
						word_nx.foreign = 1'b1;
					end
					word_nx.owner = txi_s1;
					word_nx.owned = 1'b1;
					ex_success    = 1'b1;
				end
				ex_leave = !ex_success;
			end
			dvbtm_pkg::CMD_WRITE: begin
				ex_access = 1'b1;
				if (rd_q.written) begin
					if (mine) begin
						word_nx.pending = req_s1.write_data;
						ex_success      = 1'b1;
					end
				end else if (!((rd_q.owned && !mine) || rd_q.foreign)) begin
					word_nx.pending = req_s1.write_data;
					word_nx.written = 1'b1;
					word_nx.owner   = txi_s1;
					word_nx.owned   = 1'b1;
					ex_success      = 1'b1;
				end
				ex_leave = !ex_success;
			end
			dvbtm_pkg::CMD_END, dvbtm_pkg::CMD_ABORT: begin
				ex_success = 1'b1;
				ex_leave   = 1'b1;
			end
			default: begin
				ex_success = 1'b0;
			end
		endcase
		// Leave the epoch; the last one out closes it and admits the waiters
		if (ex_leave && active_q != '0) begin
			active_nx = active_q - CW'(1);
			if (active_q == CW'(1)) begin
				ex_close   = 1'b1;
				active_nx  = waiting_q;
				waiting_nx = '0;
				epoch_nx   = epoch_q + EW'(1);
			end
		end
	end

	// Update counters and per-transaction commit flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q  <= '0;
			waiting_q <= '0;
			epoch_q   <= '0;
			tx_done_q <= '0;
		end else begin
			if (exec_fire) begin
				active_q  <= active_nx;
				waiting_q <= waiting_nx;
				epoch_q   <= epoch_nx;
			end
			if (state_q == dvbtm_pkg::ST_FLUSH) begin
				tx_done_q <= '0;
			end else if (exec_fire) begin
				if (req_s1.command == dvbtm_pkg::CMD_END) begin
					tx_done_q[txi_s1] <= 1'b1;
				end else if (req_s1.command == dvbtm_pkg::CMD_BEGIN || ex_leave) begin
					tx_done_q[txi_s1] <= 1'b0;
				end
			end
		end
	end

	// Record the read-only flag on begin
	always_ff @(posedge clk) begin
		if (exec_fire && req_s1.command == dvbtm_pkg::CMD_BEGIN) begin
			tx_ro_q[txi_s1] <= req_s1.ro_mode;
		end
	end

	// Hold the response until the receiver takes it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (exec_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_fire) begin
			rsp_q.success        <= ex_success;
			rsp_q.read_data      <= ex_rdata;
			rsp_q.admitted       <= ex_admitted;
			rsp_q.epoch_advanced <= ex_close;
			rsp_q.released_count <= ex_close ? waiting_q : '0;
			rsp_q.epoch_number   <= epoch_nx;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[sv/dvbtm_addr_fold.sv]
module dvbtm_addr_fold #(
	parameter int MEM_BYTES = 4096
) (
	input  logic [dvbtm_pkg::ADDR_W-1:0]  address,
	output logic [$clog2(MEM_BYTES)-1:0] index
);

	localparam int AW   = $clog2(MEM_BYTES);
	localparam int IN_W = dvbtm_pkg::ADDR_W;
	localparam int SPAN = 1 << IN_W;

	// Count the shifted copies of the store size that fit below the address span
	function automatic int fold_steps();
		int n;
		n = 0;
		for (int k = 0; k < IN_W; k++) begin
			if (MEM_BYTES < SPAN && (MEM_BYTES << k) < SPAN) begin
				n = k + 1;
			end
		end
		return n;
	endfunction

	localparam int STEPS = fold_steps();

	logic [IN_W-1:0] rem;

	// Reduce the address modulo the store size by restoring compare-subtract
	always_comb begin
		rem = address;
		for (int k = STEPS - 1; k >= 0; k--) begin
			if (int'(rem) >= (MEM_BYTES << k)) begin
				rem = rem - IN_W'(MEM_BYTES << k);
			end
		end
		index = AW'(rem);
	end

endmodule
